>>> rtl/ccpf_pkg.sv
// Package for the cubic curve path follower: widths, constants, item types,
// back-end state type, bezier point and arctangent table functions. No dependencies.
`default_nettype none
package ccpf_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int T_W               = FRAC_BITS + 1;
  localparam int P_W               = 21;
  localparam int B_W               = 18;
  localparam int M_W               = P_W + B_W;
  localparam int ACC_W             = M_W + 3;
  localparam int POS_W             = ACC_W - FRAC_BITS;
  localparam int CW                = 30;
  localparam int Q_DEPTH           = 2;

  localparam logic [T_W-1:0] ONE_Q      = T_W'(1) << FRAC_BITS;
  localparam logic [15:0]    C66        = 16'd43254;
  localparam logic [15:0]    C33        = 16'd21627;
  localparam logic [15:0]    STEP_RESET = 16'd655;
  localparam logic [3:0]     CP_RESET   = 4'd1;
  localparam logic [31:0]    HALF_TURN  = 32'h8000_0000;
  localparam logic [31:0]    QTR_RND    = 32'h4000_8000;

  typedef struct packed {
    logic [3:0] new_point_x;
    logic [3:0] new_point_y;
  } in_item_t;

  typedef struct packed {
    logic [19:0] pos_x;
    logic [19:0] pos_y;
    logic [15:0] heading;
    logic        segment_advanced;
  } out_item_t;

  typedef struct packed {
    logic [3:0][3:0] cpx;
    logic [3:0][3:0] cpy;
    logic [T_W-1:0]  t_cur;
    logic [T_W-1:0]  t_pri;
    logic            wrapped;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_MUL,
    BK_CORD,
    BK_EMIT
  } back_state_t;

  function automatic logic [3:0][P_W-1:0] bezier_pts(input logic [3:0][3:0] c);
    logic [P_W-1:0] s01, s12, s23;
    logic [3:0][P_W-1:0] p;
    s01 = P_W'(c[0]) + P_W'(c[1]);
    s12 = P_W'(c[1]) + P_W'(c[2]);
    s23 = P_W'(c[2]) + P_W'(c[3]);
    p[0] = (s01 * P_W'(C66) + s12 * P_W'(C33) + P_W'(1)) >> 1;
    p[1] = s12 * P_W'(C33);
    p[2] = s12 * P_W'(C66);
    p[3] = (s12 * P_W'(C66) + s23 * P_W'(C33) + P_W'(1)) >> 1;
    return p;
  endfunction

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ccpf_front.sv
// Front end: accepts ticks, advances the curve parameter, shifts control points.
// Depends on ccpf_pkg.
`default_nettype none
module ccpf_front import ccpf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step_size_wr,
  input  wire logic [15:0] step_size,
  input  wire logic     push,
  input  wire in_item_t point,
  input  wire logic     q_full,
  output logic          job_push,
  output job_t          job
);

  logic [15:0]       step;
  logic [T_W-1:0]    curve;
  logic [3:0][3:0]   cpx, cpy;
  logic [3:0][3:0]   cpx_next, cpy_next;
  logic [T_W-1:0]    curve_next;
  logic [T_W:0]      sum;
  logic              wrap;

  assign job_push = push && !q_full;

  always_comb begin
    sum  = {1'b0, curve} + (T_W+1)'(step);
    wrap = sum > (T_W+1)'(ONE_Q);
    cpx_next = cpx;
    cpy_next = cpy;
    curve_next = sum[T_W-1:0];
    if (wrap) begin
      cpx_next = {point.new_point_x, cpx[3], cpx[2], cpx[1]};
      cpy_next = {point.new_point_y, cpy[3], cpy[2], cpy[1]};
      curve_next = '0;
    end
    job.cpx     = cpx_next;
    job.cpy     = cpy_next;
    job.t_cur   = curve_next;
    job.t_pri   = curve;
    job.wrapped = wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= STEP_RESET;
      curve <= '0;
      cpx   <= {4{CP_RESET}};
      cpy   <= {4{CP_RESET}};
    end else begin
      if (step_size_wr) begin
        step <= step_size;
      end
      if (job_push) begin
        curve <= curve_next;
        cpx   <= cpx_next;
        cpy   <= cpy_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ccpf_queue.sv
// Short job queue between the front and back ends.
// Depends on ccpf_pkg.
`default_nettype none
module ccpf_queue import ccpf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire job_t wr_data,
  input  wire logic rd,
  output job_t      rd_data,
  output logic      q_full,
  output logic      q_empty
);

  localparam int PTR_W = $clog2(Q_DEPTH);

  job_t             mem [Q_DEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [PTR_W:0]   cnt;

  assign q_full  = cnt == (PTR_W+1)'(Q_DEPTH);
  assign q_empty = cnt == '0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == PTR_W'(Q_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
      end
      if (rd) begin
        rp <= (rp == PTR_W'(Q_DEPTH - 1)) ? '0 : rp + PTR_W'(1);
      end
      cnt <= cnt + (PTR_W+1)'(wr) - (PTR_W+1)'(rd);
    end
  end

endmodule
`default_nettype wire

>>> rtl/ccpf_back.sv
// Back end: curve evaluation on one shared multiplier, CORDIC heading, result register.
// Depends on ccpf_pkg.
`default_nettype none
module ccpf_back import ccpf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire job_t q_data,
  output logic      q_pop,
  input  wire logic pop,
  output logic      empty,
  output out_item_t result
);

  localparam int CI_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  back_state_t          st, st_next;
  job_t                 job;
  logic [3:0][P_W-1:0]  px, py;
  logic [3:0]           stp;
  logic                 pass;
  logic [T_W-1:0]       uu, tt;
  logic [3:0][B_W-1:0]  bw;
  logic [ACC_W-1:0]     acc;
  logic [POS_W-1:0]     ox, oy, cx, cy;
  logic signed [CW-1:0] h, v;
  logic [31:0]          z;
  logic [CI_W-1:0]      ci;
  logic [15:0]          held_heading;
  logic                 out_valid;

  logic [T_W-1:0]       t, u;
  logic [P_W-1:0]       ma;
  logic [B_W-1:0]       mb;
  logic [M_W-1:0]       prod, prod_r;
  logic [T_W-1:0]       rnd;
  logic [B_W-1:0]       rnd3;
  logic [ACC_W-1:0]     acc_r;
  logic [POS_W-1:0]     pos_r;
  logic signed [POS_W:0] dx, dy;
  logic signed [CW-1:0] h0, v0, hs, vs;
  logic                 emit;

  assign empty = !out_valid;
  assign emit  = (st == BK_EMIT) && (!out_valid || pop);
  assign q_pop = (st == BK_IDLE) && !q_empty;

  always_comb begin
    t = pass ? job.t_cur : job.t_pri;
    u = ONE_Q - t;
    ma = '0;
    mb = '0;
    case (stp)
      4'd0: begin ma = P_W'(u);  mb = B_W'(u); end
      4'd1: begin ma = P_W'(t);  mb = B_W'(t); end
      4'd2: begin ma = P_W'(uu); mb = B_W'(u); end
      4'd3: begin ma = P_W'(uu); mb = B_W'(t); end
      4'd4: begin ma = P_W'(tt); mb = B_W'(u); end
      4'd5: begin ma = P_W'(tt); mb = B_W'(t); end
      4'd6, 4'd7, 4'd8, 4'd9: begin
        ma = px[stp[1:0] - 2'd2];
        mb = bw[stp[1:0] - 2'd2];
      end
      4'd10, 4'd11, 4'd12, 4'd13: begin
        ma = py[stp[1:0] - 2'd2];
        mb = bw[stp[1:0] - 2'd2];
      end
      default: begin ma = '0; mb = '0; end
    endcase
    prod   = M_W'(ma) * M_W'(mb);
    prod_r = prod + M_W'(1 << (FRAC_BITS - 1));
    rnd    = prod_r[FRAC_BITS +: T_W];
    rnd3   = {B_W'(rnd) << 1} + B_W'(rnd);
    acc_r  = acc + ACC_W'(1 << (FRAC_BITS - 1));
    pos_r  = acc_r[ACC_W-1:FRAC_BITS];
    dx = $signed({1'b0, cx}) - $signed({1'b0, ox});
    dy = $signed({1'b0, pos_r}) - $signed({1'b0, oy});
    h0 = CW'(dy);
    v0 = CW'(dx);
    hs = h >>> ci;
    vs = v >>> ci;
  end

  always_comb begin
    st_next = st;
    unique case (st)
      BK_IDLE: if (!q_empty) st_next = BK_LOAD;
      BK_LOAD: st_next = BK_MUL;
      BK_MUL: begin
        if (stp == 4'd14 && pass) begin
          st_next = (job.wrapped || (dx == '0 && dy == '0)) ? BK_EMIT : BK_CORD;
        end
      end
      BK_CORD: if (ci == CI_W'(CORDIC_STEPS - 1)) st_next = BK_EMIT;
      BK_EMIT: if (emit) st_next = BK_IDLE;
      default: st_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BK_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      held_heading <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (st == BK_CORD && ci == CI_W'(CORDIC_STEPS - 1)) begin
        held_heading <= 16'((z + (v > 0 ? atan_entry(5'(ci)) : -atan_entry(5'(ci)))
                        + QTR_RND) >> 16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_data;
    end
    case (st)
      BK_LOAD: begin
        px   <= bezier_pts(job.cpx);
        py   <= bezier_pts(job.cpy);
        stp  <= '0;
        pass <= 1'b0;
      end
      BK_MUL: begin
        case (stp)
          4'd0: uu <= rnd;
          4'd1: tt <= rnd;
          4'd2: bw[0] <= B_W'(rnd);
          4'd3: bw[1] <= rnd3;
          4'd4: bw[2] <= rnd3;
          4'd5: bw[3] <= B_W'(rnd);
          4'd6: acc <= ACC_W'(prod);
          4'd10: begin
            acc <= ACC_W'(prod);
            if (pass) cx <= pos_r;
            else      ox <= pos_r;
          end
          4'd14: begin
            if (pass) cy <= pos_r;
            else      oy <= pos_r;
          end
          default: acc <= acc + ACC_W'(prod);
        endcase
        if (stp == 4'd14) begin
          stp  <= '0;
          pass <= 1'b1;
          if (h0 < 0) begin
            h <= -h0;
            v <= -v0;
            z <= HALF_TURN;
          end else begin
            h <= h0;
            v <= v0;
            z <= '0;
          end
          ci <= '0;
        end else begin
          stp <= stp + 4'd1;
        end
      end
      BK_CORD: begin
        if (v > 0) begin
          h <= h + vs;
          v <= v - hs;
          z <= z + atan_entry(5'(ci));
        end else begin
          h <= h - vs;
          v <= v + hs;
          z <= z - atan_entry(5'(ci));
        end
        ci <= ci + CI_W'(1);
      end
      default: ;
    endcase
    if (emit) begin
      result.pos_x            <= (|cx[POS_W-1:20]) ? 20'hFFFFF : cx[19:0];
      result.pos_y            <= (|cy[POS_W-1:20]) ? 20'hFFFFF : cy[19:0];
      result.heading          <= held_heading;
      result.segment_advanced <= job.wrapped;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cubic_curve_path_follower.sv
// Top level of the cubic curve path follower: front end, job queue, back end.
// Depends on ccpf_pkg, ccpf_front, ccpf_queue, ccpf_back.
//
//   channel  | signals                       | transfer
//   ---------+-------------------------------+----------------------------
//   input    | push, full, point             | push && !full
//   result   | pop, empty, result            | pop && !empty
//   config   | step_size_wr, step_size       | step_size_wr
//
// Each tick passes in the back end through queue read, load, two curve
// evaluations on the one shared multiplier, then one CORDIC iteration
// per cycle, then emit. A held heading skips the CORDIC. Emit stalls
// while the result register is full and pop is low.
// The front end takes a tick every cycle while the two-entry queue has room.
// Reset is synchronous and ready at once.
`default_nettype none
module cubic_curve_path_follower import ccpf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step_size_wr,
  input  wire logic [15:0] step_size,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    point,
  input  wire logic        pop,
  output logic             empty,
  output out_item_t        result
);

  job_t job_in, job_out;
  logic job_push, job_pop, q_full, q_empty;

  assign full = q_full;

  ccpf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .step_size_wr (step_size_wr),
    .step_size    (step_size),
    .push         (push),
    .point        (point),
    .q_full       (q_full),
    .job_push     (job_push),
    .job          (job_in)
  );

  ccpf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_data (job_in),
    .rd      (job_pop),
    .rd_data (job_out),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  ccpf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (job_out),
    .q_pop   (job_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule
`default_nettype wire

>>> tb/ccpf_checker.sv
// Checker for the cubic curve path follower: watches the point and result
// channels, predicts each tick's result and compares. Depends on ccpf_pkg.
`timescale 1ns / 1ps
module ccpf_checker import ccpf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step_size_wr,
  input  wire logic [15:0] step_size,
  input  wire logic        push,
  input  wire logic        full,
  input  wire in_item_t    point,
  input  wire logic        pop,
  input  wire logic        empty,
  input  wire out_item_t   result,
  output int               fail_count,
  output int               pending
);

  logic [3:0]  ctl_x [4];
  logic [3:0]  ctl_y [4];
  logic [63:0] t_now, t_old, step_q;
  logic [15:0] last_heading;
  out_item_t   expected_q [$];

  assign pending = expected_q.size();

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'd32768) >> 16;
  endfunction

  function automatic logic [63:0] curve_at(input logic [3:0] c [4], input logic [63:0] t);
    logic [63:0] c66, c33, s01, s12, s23, p0, p1, p2, p3, u, uu, tt;
    c66 = 64'd43254;
    c33 = 64'd21627;
    s01 = c[0] + c[1];
    s12 = c[1] + c[2];
    s23 = c[2] + c[3];
    p0 = (s01 * c66 + s12 * c33 + 1) >> 1;
    p1 = s12 * c33;
    p2 = s12 * c66;
    p3 = (s12 * c66 + s23 * c33 + 1) >> 1;
    u = 64'd65536 - t;
    uu = qmul(u, u);
    tt = qmul(t, t);
    return (p0 * qmul(uu, u) + p1 * 3 * qmul(uu, t) + p2 * 3 * qmul(tt, u)
            + p3 * qmul(tt, t) + 64'd32768) >> 16;
  endfunction

  function automatic logic [15:0] angle_of(input longint h, input longint v);
    logic [31:0] z;
    longint hs, vs;
    logic [31:0] tab [16];
    tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D};
    z = 0;
    if (h < 0) begin
      h = -h;
      v = -v;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      hs = h >>> i;
      vs = v >>> i;
      if (v > 0) begin
        h += vs;
        v -= hs;
        z += tab[i];
      end else begin
        h -= vs;
        v += hs;
        z -= tab[i];
      end
    end
    z += 32'h4000_8000;
    return z[31:16];
  endfunction

  function automatic logic [19:0] sat20(input logic [63:0] p);
    return (p > 64'hFFFFF) ? 20'hFFFFF : p[19:0];
  endfunction

  task automatic predict_tick(input in_item_t pt);
    out_item_t   e;
    logic        wrap;
    logic [63:0] cx, cy, ox, oy;
    longint      dx, dy;
    wrap = 0;
    t_old = t_now;
    t_now = t_now + step_q;
    if (t_now > 64'd65536) begin
      for (int i = 0; i < 3; i++) begin
        ctl_x[i] = ctl_x[i+1];
        ctl_y[i] = ctl_y[i+1];
      end
      ctl_x[3] = pt.new_point_x;
      ctl_y[3] = pt.new_point_y;
      t_now = 0;
      wrap = 1;
    end
    cx = curve_at(ctl_x, t_now);
    cy = curve_at(ctl_y, t_now);
    ox = curve_at(ctl_x, t_old);
    oy = curve_at(ctl_y, t_old);
    dx = longint'(cx) - longint'(ox);
    dy = longint'(cy) - longint'(oy);
    if (!wrap && (dx != 0 || dy != 0)) last_heading = angle_of(dy, dx);
    e.pos_x = sat20(cx);
    e.pos_y = sat20(cy);
    e.heading = last_heading;
    e.segment_advanced = wrap;
    expected_q.push_back(e);
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        ctl_x[i] = 1;
        ctl_y[i] = 1;
      end
      t_now = 0;
      t_old = 0;
      last_heading = 0;
      step_q = 655;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no expected result");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (result.pos_x !== e.pos_x) begin
            $error("pos_x: expected %0d actual %0d", e.pos_x, result.pos_x);
            fail_count++;
          end
          if (result.pos_y !== e.pos_y) begin
            $error("pos_y: expected %0d actual %0d", e.pos_y, result.pos_y);
            fail_count++;
          end
          if (result.heading !== e.heading) begin
            $error("heading: expected %0d actual %0d", e.heading, result.heading);
            fail_count++;
          end
          if (result.segment_advanced !== e.segment_advanced) begin
            $error("segment_advanced: expected %0d actual %0d", e.segment_advanced,
                   result.segment_advanced);
            fail_count++;
          end
        end
      end
      if (push && !full) predict_tick(point);
      if (step_size_wr) step_q = step_size;
    end
  end

endmodule

>>> tb/tb_cubic_curve_path_follower.sv
// Testbench top for the cubic curve path follower: drives ticks and step
// size settings, stalls the result side. Depends on ccpf_pkg and ccpf_checker.
`timescale 1ns / 1ps
module tb_cubic_curve_path_follower;
  import ccpf_pkg::*;

  localparam int WATCHDOG = 20000;

  logic      clk = 0;
  logic      rst = 1;
  logic      step_size_wr = 0;
  logic [15:0] step_size = 0;
  logic      push = 0;
  logic      full;
  in_item_t  point = '0;
  logic      pop = 0;
  logic      empty;
  out_item_t result;
  int        fail_count, pending, idle_cycles;
  logic      pop_burst = 0;

  always #10 clk = ~clk;

  cubic_curve_path_follower u_dut (
    .clk(clk), .rst(rst), .step_size_wr(step_size_wr), .step_size(step_size),
    .push(push), .full(full), .point(point), .pop(pop), .empty(empty), .result(result)
  );

  ccpf_checker u_checker (
    .clk(clk), .rst(rst), .step_size_wr(step_size_wr), .step_size(step_size),
    .push(push), .full(full), .point(point), .pop(pop), .empty(empty),
    .result(result), .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
  endfunction

  task automatic send_point(input logic [3:0] x, input logic [3:0] y, input bit nogap);
    int g;
    g = nogap ? 0 : gap_len();
    if (g > 0) begin
      push <= 0;
      repeat (g) @(posedge clk);
    end
    push <= 1;
    point <= '{new_point_x: x, new_point_y: y};
    do @(posedge clk); while (full);
  endtask

  task automatic drain_and_set(input logic [15:0] v);
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    step_size_wr <= 1;
    step_size <= v;
    @(posedge clk);
    step_size_wr <= 0;
  endtask

  task automatic run_phase(input int n, input bit noise);
    logic [3:0] x, y;
    bit burst;
    burst = $urandom_range(0, 3) == 0;
    for (int i = 0; i < n; i++) begin
      x = noise ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      y = noise ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      send_point(x, y, burst);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
    end else if (pop_burst) begin
      pop <= 1;
    end else begin
      pop <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && idle_cycles > WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] steps [6];
    steps = '{16'd1, 16'd65535, 16'd32768, 16'd0, 16'd8192, 16'd21845};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_point(4'd8, 4'd1, 1);
    send_point(4'd1, 4'd8, 1);
    drain_and_set(16'd65535);
    send_point(4'd8, 4'd8, 1);
    send_point(4'd1, 4'd1, 1);
    send_point(4'd15, 4'd15, 1);
    send_point(4'd0, 4'd0, 1);
    send_point(4'd15, 4'd0, 0);
    send_point(4'd0, 4'd15, 0);
    send_point(4'd10, 4'd5, 0);
    send_point(4'd5, 4'd10, 0);
    drain_and_set(16'd32768);
    for (int i = 0; i < 6; i++) send_point(4'(i * 3), 4'(15 - i), 0);
    drain_and_set(16'd0);
    for (int i = 0; i < 3; i++) send_point(4'd3, 4'd4, 0);
    drain_and_set(16'd65535);
    pop_burst <= 1;
    run_phase(200, 0);
    pop_burst <= 0;
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 2 == 0) drain_and_set(steps[ph % 6]);
      else drain_and_set(16'($urandom_range(1, 65535)));
      run_phase(110, ph % 4 == 3);
    end
    drain_and_set(16'd16384);
    run_phase(150, 0);
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
